// ----- rtl/mhtq_pkg.sv -----
// Shared types and codes for the min-heap timer queue.
package mhtq_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_POP_LOAD,
    ST_DN_CMP,
    ST_FIN
  } state_t;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

endpackage

// ----- rtl/mhtq_ram.sv -----
// Heap entry store: one write port and two registered read ports.
module mhtq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ----- rtl/min_heap_timer_queue.sv -----
// Min-heap timer queue: push sifts up, pop returns the minimum and sifts down.
// A full push or an empty pop is answered straight from idle. A push runs ST_UP_CHK, then
// ST_UP_CMP once per level the entry moves up (one memory read and compare per level); a pop
// runs ST_POP_LOAD, then ST_DN_CMP per level; ST_FIN writes the entry at the root or a leaf.
// busy drops in the cycle done pulses, so the next item can be accepted then; the receiver
// cannot stall. Reset (synchronous) empties the heap; entries are not cleared.
module min_heap_timer_queue import mhtq_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [31:0] key,
  input  logic [15:0] handle,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] out_key,
  output logic [15:0] out_handle
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CH_W = IW + 2;
  localparam int EW   = KEY_BITS + 16;
  localparam logic [CW-1:0]   CAP_COUNT   = CW'(CAPACITY);
  localparam logic [CH_W-1:0] FIRST_CHILD = CH_W'(2);

  state_t state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [IW-1:0]       hole, hole_next;
  logic [CH_W-1:0]     child, child_next;
  logic [KEY_BITS-1:0] cur_key, cur_key_next;
  logic [15:0]         cur_handle, cur_handle_next;
  logic [31:0]         res_key, res_key_next;
  logic [15:0]         res_handle, res_handle_next;
  logic                done_next;
  logic [1:0]          status_next;
  logic [31:0]         out_key_next;
  logic [15:0]         out_handle_next;

  logic          we;
  logic [IW-1:0] waddr, raddr0, raddr1;
  logic [EW-1:0] wdata, rdata0, rdata1;

  logic [KEY_BITS-1:0] key_ext, rd0_key, rd1_key, sel_key;
  logic [15:0]         rd0_handle, rd1_handle, sel_handle;
  logic [CW-1:0]       count_dec;
  logic [IW-1:0]       hole_dec, up_parent, parent_dec, up_grand, sel_idx;
  logic [CH_W-1:0]     n_ext, next_child;
  logic                pick_left;

  mhtq_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(EW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr0(raddr0),
    .raddr1(raddr1),
    .rdata0(rdata0),
    .rdata1(rdata1)
  );

  assign busy       = (state != ST_IDLE);
  assign key_ext    = KEY_BITS'(key);
  assign rd0_key    = rdata0[EW-1:16];
  assign rd0_handle = rdata0[15:0];
  assign rd1_key    = rdata1[EW-1:16];
  assign rd1_handle = rdata1[15:0];
  assign count_dec  = count - 1'b1;
  assign hole_dec   = hole - 1'b1;
  assign up_parent  = hole_dec >> 1;
  assign parent_dec = up_parent - 1'b1;
  assign up_grand   = parent_dec >> 1;
  assign n_ext      = CH_W'(count);

  // The left child wins only when it is alone or strictly smaller; a tie goes right.
  assign pick_left  = (child == n_ext) || (rd1_key > rd0_key);
  assign sel_idx    = pick_left ? IW'(child - 1'b1) : IW'(child);
  assign sel_key    = pick_left ? rd0_key : rd1_key;
  assign sel_handle = pick_left ? rd0_handle : rd1_handle;
  assign next_child = (CH_W'(sel_idx) + 1'b1) << 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    hole       <= hole_next;
    child      <= child_next;
    cur_key    <= cur_key_next;
    cur_handle <= cur_handle_next;
    res_key    <= res_key_next;
    res_handle <= res_handle_next;
    status     <= status_next;
    out_key    <= out_key_next;
    out_handle <= out_handle_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    hole_next       = hole;
    child_next      = child;
    cur_key_next    = cur_key;
    cur_handle_next = cur_handle;
    res_key_next    = res_key;
    res_handle_next = res_handle;
    done_next       = 1'b0;
    status_next     = status;
    out_key_next    = out_key;
    out_handle_next = out_handle;
    we              = 1'b0;
    waddr           = hole;
    wdata           = {cur_key, cur_handle};
    raddr0          = '0;
    raddr1          = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          if (action == ACT_PUSH) begin
            if (count == CAP_COUNT) begin
              done_next       = 1'b1;
              status_next     = STAT_FULL;
              out_key_next    = '0;
              out_handle_next = '0;
            end else begin
              count_next      = count + 1'b1;
              hole_next       = IW'(count);
              cur_key_next    = key_ext;
              cur_handle_next = handle;
              res_key_next    = '0;
              res_handle_next = '0;
              state_next      = ST_UP_CHK;
            end
          end else begin
            if (count == '0) begin
              done_next       = 1'b1;
              status_next     = STAT_EMPTY;
              out_key_next    = '0;
              out_handle_next = '0;
            end else begin
              raddr0     = '0;
              raddr1     = IW'(count_dec);
              state_next = ST_POP_LOAD;
            end
          end
        end
      end

      ST_UP_CHK: begin
        if (hole == '0) begin
          we              = 1'b1;
          done_next       = 1'b1;
          status_next     = STAT_OK;
          out_key_next    = res_key;
          out_handle_next = res_handle;
          state_next      = ST_IDLE;
        end else begin
          raddr0     = up_parent;
          state_next = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        we = 1'b1;
        if (rd0_key > cur_key) begin
          // Parent moves down into the hole; fetch the next ancestor meanwhile.
          wdata     = rdata0;
          hole_next = up_parent;
          if (up_parent == '0) begin
            state_next = ST_FIN;
          end else begin
            raddr0 = up_grand;
          end
        end else begin
          done_next       = 1'b1;
          status_next     = STAT_OK;
          out_key_next    = res_key;
          out_handle_next = res_handle;
          state_next      = ST_IDLE;
        end
      end

      ST_POP_LOAD: begin
        // rdata0 holds the root, rdata1 the last entry that refills the root.
        count_next      = count_dec;
        hole_next       = '0;
        cur_key_next    = rd1_key;
        cur_handle_next = rd1_handle;
        res_key_next    = 32'(rd0_key);
        res_handle_next = rd0_handle;
        if (FIRST_CHILD <= CH_W'(count_dec)) begin
          raddr0     = IW'(FIRST_CHILD - 1'b1);
          raddr1     = IW'(FIRST_CHILD);
          child_next = FIRST_CHILD;
          state_next = ST_DN_CMP;
        end else begin
          we              = 1'b1;
          waddr           = '0;
          wdata           = rdata1;
          done_next       = 1'b1;
          status_next     = STAT_OK;
          out_key_next    = 32'(rd0_key);
          out_handle_next = rd0_handle;
          state_next      = ST_IDLE;
        end
      end

      ST_DN_CMP: begin
        we = 1'b1;
        if (cur_key > sel_key) begin
          wdata     = {sel_key, sel_handle};
          hole_next = sel_idx;
          if (next_child <= n_ext) begin
            raddr0     = IW'(next_child - 1'b1);
            raddr1     = IW'(next_child);
            child_next = next_child;
          end else begin
            state_next = ST_FIN;
          end
        end else begin
          done_next       = 1'b1;
          status_next     = STAT_OK;
          out_key_next    = res_key;
          out_handle_next = res_handle;
          state_next      = ST_IDLE;
        end
      end

      ST_FIN: begin
        we              = 1'b1;
        done_next       = 1'b1;
        status_next     = STAT_OK;
        out_key_next    = res_key;
        out_handle_next = res_handle;
        state_next      = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_COUNT)
    else $error("entry count exceeds capacity");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while an item is still in progress");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_POP && count == '0)
    |=> (done && status == STAT_EMPTY))
    else $error("pop of an empty heap did not report empty");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_PUSH && count != CAP_COUNT)
    |=> (count == $past(count) + 1'b1))
    else $error("accepted push did not grow the heap by one");

endmodule
